// ===== hw/rtl/tcq_pkg.sv =====
package tcq_pkg;

   // Queue geometry.
   localparam int QUEUE_DEPTH = 32;
   localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   // Fixed field widths.
   localparam int TAG_W   = 16;
   localparam int TIME_W  = 48;
   localparam int DELAY_W = 32;
   localparam int REQ_W   = 2;
   localparam int OUT_COUNT_W = 6;

   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [COUNT_W-1:0] count_type;

   // Request codes; the fourth code is unused and ignored.
   typedef enum logic [REQ_W-1:0] {
      REQ_ENQUEUE = 2'd0,
      REQ_TAKE    = 2'd1,
      REQ_DROP    = 2'd2
   } req_code_type;

   // One stored entry.
   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] ready_time;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_SHIFT,
      ST_HEAD_RD,
      ST_RESPOND
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;
      logic do_enqueue;
      logic do_drop;
      logic scan_start;
      logic scan_step;
      logic shift_start;
      logic shift_step;
      logic take_commit;
      logic head_read;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      req_code_type req;
      logic         full;
      logic         empty;
      logic         step_done;
      logic         found;
   } status_type;

   // Ring slot arithmetic with wrap at the queue depth.
   function automatic slot_type next_slot(slot_type s);
      return (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
   endfunction

   function automatic slot_type prev_slot(slot_type s);
      return (s == '0) ? SLOT_W'(QUEUE_DEPTH - 1) : s - SLOT_W'(1);
   endfunction

endpackage

// ===== hw/rtl/timed_command_queue.sv =====
// Bounded ring queue of timed commands, one request at a time. A request is
// taken when start is high and busy is low. Its single result appears on the
// rsp_ ports for exactly one cycle with rsp_valid high. The receiver cannot
// stall it, so it must take the result in that cycle. Enqueue, drop, a take
// on an empty queue and the unused code go from the execute state through the
// head read to the response state, and busy falls in the cycle after the
// strobe. A take on a non-empty queue walks the held entries from the head
// through the single read port of the entry memory, one entry a cycle. If a
// ready entry is found, it then moves the later entries down one place a
// cycle, reading them through the same port. Entry storage needs no clearing
// after reset; a slot that holds no entry is read only by the head read of an
// empty queue, whose head tag is then forced to zero.
module timed_command_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [tcq_pkg::REQ_W-1:0]            req_type,
   input  logic [tcq_pkg::TIME_W-1:0]           req_now_time,
   input  logic [tcq_pkg::DELAY_W-1:0]          req_delay_ticks,
   input  logic [tcq_pkg::TAG_W-1:0]            req_cmd_tag,
   output logic                                 rsp_valid,
   output logic                                 rsp_done_res,
   output logic [tcq_pkg::TAG_W-1:0]            rsp_taken_tag,
   output logic [tcq_pkg::TIME_W-1:0]           rsp_taken_ready_time,
   output logic [tcq_pkg::TAG_W-1:0]            rsp_head_tag,
   output logic [tcq_pkg::OUT_COUNT_W-1:0]      rsp_entry_count
);

   tcq_pkg::cmd_type    cmd;
   tcq_pkg::status_type status;

   // Sequencer.
   tcq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // Queue storage, pointers and search logic.
   tcq_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_type             (req_type),
      .req_now_time         (req_now_time),
      .req_delay_ticks      (req_delay_ticks),
      .req_cmd_tag          (req_cmd_tag),
      .rsp_done_res         (rsp_done_res),
      .rsp_taken_tag        (rsp_taken_tag),
      .rsp_taken_ready_time (rsp_taken_ready_time),
      .rsp_head_tag         (rsp_head_tag),
      .rsp_entry_count      (rsp_entry_count)
   );

endmodule

// ===== hw/rtl/tcq_ram.sv =====
module tcq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds when idle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tcq_datapath.sv =====
module tcq_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tcq_pkg::cmd_type                     cmd,
   output tcq_pkg::status_type                  status,
   input  logic [tcq_pkg::REQ_W-1:0]            req_type,
   input  logic [tcq_pkg::TIME_W-1:0]           req_now_time,
   input  logic [tcq_pkg::DELAY_W-1:0]          req_delay_ticks,
   input  logic [tcq_pkg::TAG_W-1:0]            req_cmd_tag,
   output logic                                 rsp_done_res,
   output logic [tcq_pkg::TAG_W-1:0]            rsp_taken_tag,
   output logic [tcq_pkg::TIME_W-1:0]           rsp_taken_ready_time,
   output logic [tcq_pkg::TAG_W-1:0]            rsp_head_tag,
   output logic [tcq_pkg::OUT_COUNT_W-1:0]      rsp_entry_count
);

   // Latched request.
   logic [tcq_pkg::REQ_W-1:0]   req_ff, req_in;
   logic [tcq_pkg::TIME_W-1:0]  now_ff, now_in;
   logic [tcq_pkg::DELAY_W-1:0] delay_ff, delay_in;
   logic [tcq_pkg::TAG_W-1:0]   tag_ff, tag_in;

   // Ring pointers and fill count.
   tcq_pkg::slot_type  head_ff, head_in;
   tcq_pkg::slot_type  tail_ff, tail_in;
   tcq_pkg::count_type count_ff, count_in;

   // Scan and shift walker.
   tcq_pkg::count_type rd_idx_ff, rd_idx_in;
   tcq_pkg::slot_type  rd_ptr_ff, rd_ptr_in;
   logic               pend_ff, pend_in;
   tcq_pkg::count_type cmp_idx_ff, cmp_idx_in;
   tcq_pkg::slot_type  cmp_slot_ff, cmp_slot_in;
   tcq_pkg::slot_type  wr_ptr_ff, wr_ptr_in;

   // Best ready entry found so far.
   logic                        found_ff, found_in;
   tcq_pkg::count_type          best_idx_ff, best_idx_in;
   tcq_pkg::slot_type           best_slot_ff, best_slot_in;
   logic [tcq_pkg::TIME_W-1:0]  best_time_ff, best_time_in;
   logic [tcq_pkg::TAG_W-1:0]   best_tag_ff, best_tag_in;

   // Result registers.
   logic                        done_ff, done_in;
   logic [tcq_pkg::TAG_W-1:0]   taken_tag_ff, taken_tag_in;
   logic [tcq_pkg::TIME_W-1:0]  taken_time_ff, taken_time_in;

   // Memory port signals.
   logic                           ram_wr_en;
   tcq_pkg::slot_type              ram_wr_addr;
   tcq_pkg::entry_type             ram_wr_entry;
   logic                           ram_rd_en;
   tcq_pkg::slot_type              ram_rd_addr;
   logic [tcq_pkg::ENTRY_W-1:0]    ram_rd_data;
   tcq_pkg::entry_type             rd_entry;

   logic                           issue;
   logic [tcq_pkg::TIME_W:0]       ready_sum;
   logic [tcq_pkg::TIME_W-1:0]     ready_sat;

   assign rd_entry = tcq_pkg::entry_type'(ram_rd_data);

   // The walker reads while its offset is below the fill count.
   assign issue = (rd_idx_ff < count_ff);

   // Ready time of a new entry, saturated at the top of the time range.
   assign ready_sum = {1'b0, now_ff} + {{(tcq_pkg::TIME_W + 1 - tcq_pkg::DELAY_W){1'b0}}, delay_ff};
   assign ready_sat = ready_sum[tcq_pkg::TIME_W] ? '1 : ready_sum[tcq_pkg::TIME_W-1:0];

   // Status toward the controller.
   always_comb begin
      status.req       = tcq_pkg::req_code_type'(req_ff);
      status.full      = (count_ff == tcq_pkg::COUNT_W'(tcq_pkg::QUEUE_DEPTH));
      status.empty     = (count_ff == '0);
      status.step_done = !pend_ff && (rd_idx_ff == count_ff);
      status.found     = found_ff;
   end

   // Memory port selection.
   always_comb begin
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_ptr_ff;
      ram_wr_entry = rd_entry;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = rd_ptr_ff;
      if (cmd.do_enqueue) begin
         ram_wr_en               = 1'b1;
         ram_wr_addr             = tail_ff;
         ram_wr_entry.tag        = tag_ff;
         ram_wr_entry.ready_time = ready_sat;
      end else if (cmd.shift_step && pend_ff) begin
         ram_wr_en = 1'b1;
      end
      if (cmd.head_read) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = head_ff;
      end else if ((cmd.scan_step || cmd.shift_step) && !cmd.shift_start && issue) begin
         ram_rd_en = 1'b1;
      end
   end

   // Next-state logic of the datapath registers.
   always_comb begin
      req_in        = req_ff;
      now_in        = now_ff;
      delay_in      = delay_ff;
      tag_in        = tag_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      rd_ptr_in     = rd_ptr_ff;
      pend_in       = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      cmp_slot_in   = cmp_slot_ff;
      wr_ptr_in     = wr_ptr_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_slot_in  = best_slot_ff;
      best_time_in  = best_time_ff;
      best_tag_in   = best_tag_ff;
      done_in       = done_ff;
      taken_tag_in  = taken_tag_ff;
      taken_time_in = taken_time_ff;

      // Capture a new item and clear its result.
      if (cmd.latch) begin
         req_in        = req_type;
         now_in        = req_now_time;
         delay_in      = req_delay_ticks;
         tag_in        = req_cmd_tag;
         done_in       = 1'b0;
         taken_tag_in  = '0;
         taken_time_in = '0;
      end

      // Append at the tail.
      if (cmd.do_enqueue) begin
         tail_in  = tcq_pkg::next_slot(tail_ff);
         count_in = count_ff + tcq_pkg::COUNT_W'(1);
         done_in  = 1'b1;
      end

      // Discard the head.
      if (cmd.do_drop) begin
         head_in  = tcq_pkg::next_slot(head_ff);
         count_in = count_ff - tcq_pkg::COUNT_W'(1);
         done_in  = 1'b1;
      end

      // Start the scan at the head.
      if (cmd.scan_start) begin
         rd_idx_in = '0;
         rd_ptr_in = head_ff;
         found_in  = 1'b0;
      end

      // Start closing the gap just after the chosen entry.
      if (cmd.shift_start) begin
         rd_idx_in = best_idx_ff + tcq_pkg::COUNT_W'(1);
         rd_ptr_in = tcq_pkg::next_slot(best_slot_ff);
         wr_ptr_in = best_slot_ff;
      end else if ((cmd.scan_step || cmd.shift_step) && issue) begin
         rd_idx_in   = rd_idx_ff + tcq_pkg::COUNT_W'(1);
         rd_ptr_in   = tcq_pkg::next_slot(rd_ptr_ff);
         cmp_idx_in  = rd_idx_ff;
         cmp_slot_in = rd_ptr_ff;
         pend_in     = 1'b1;
      end

      // Keep the earliest ready entry; a later one must be strictly earlier.
      if (cmd.scan_step && pend_ff) begin
         if ((rd_entry.ready_time <= now_ff) &&
             (!found_ff || (rd_entry.ready_time < best_time_ff))) begin
            found_in     = 1'b1;
            best_idx_in  = cmp_idx_ff;
            best_slot_in = cmp_slot_ff;
            best_time_in = rd_entry.ready_time;
            best_tag_in  = rd_entry.tag;
         end
      end

      // Each moved entry advances the write pointer.
      if (cmd.shift_step && pend_ff) begin
         wr_ptr_in = tcq_pkg::next_slot(wr_ptr_ff);
      end

      // The gap is closed: shorten the queue and report the entry.
      if (cmd.take_commit) begin
         tail_in       = tcq_pkg::prev_slot(tail_ff);
         count_in      = count_ff - tcq_pkg::COUNT_W'(1);
         done_in       = 1'b1;
         taken_tag_in  = best_tag_ff;
         taken_time_in = best_time_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      now_ff        <= now_in;
      delay_ff      <= delay_in;
      tag_ff        <= tag_in;
      rd_idx_ff     <= rd_idx_in;
      rd_ptr_ff     <= rd_ptr_in;
      cmp_idx_ff    <= cmp_idx_in;
      cmp_slot_ff   <= cmp_slot_in;
      wr_ptr_ff     <= wr_ptr_in;
      best_idx_ff   <= best_idx_in;
      best_slot_ff  <= best_slot_in;
      best_time_ff  <= best_time_in;
      best_tag_ff   <= best_tag_in;
      done_ff       <= done_in;
      taken_tag_ff  <= taken_tag_in;
      taken_time_ff <= taken_time_in;
   end

   // Entry storage.
   tcq_ram #(
      .WIDTH(tcq_pkg::ENTRY_W),
      .DEPTH(tcq_pkg::QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Result fields; the head tag comes from the final head read.
   assign rsp_done_res         = done_ff;
   assign rsp_taken_tag        = taken_tag_ff;
   assign rsp_taken_ready_time = taken_time_ff;
   assign rsp_head_tag         = (count_ff == '0) ? '0 : rd_entry.tag;
   assign rsp_entry_count      = tcq_pkg::OUT_COUNT_W'(count_ff);

endmodule

// ===== hw/rtl/tcq_ctrl.sv =====
module tcq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   output tcq_pkg::cmd_type    cmd,
   input  tcq_pkg::status_type status
);

   tcq_pkg::state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcq_pkg::ST_IDLE: begin
            if (start) begin
               state_in = tcq_pkg::ST_EXEC;
            end
         end
         tcq_pkg::ST_EXEC: begin
            if ((status.req == tcq_pkg::REQ_TAKE) && !status.empty) begin
               state_in = tcq_pkg::ST_SCAN;
            end else begin
               state_in = tcq_pkg::ST_HEAD_RD;
            end
         end
         tcq_pkg::ST_SCAN: begin
            if (status.step_done) begin
               state_in = status.found ? tcq_pkg::ST_SHIFT : tcq_pkg::ST_HEAD_RD;
            end
         end
         tcq_pkg::ST_SHIFT: begin
            if (status.step_done) begin
               state_in = tcq_pkg::ST_HEAD_RD;
            end
         end
         tcq_pkg::ST_HEAD_RD: begin
            state_in = tcq_pkg::ST_RESPOND;
         end
         tcq_pkg::ST_RESPOND: begin
            state_in = tcq_pkg::ST_IDLE;
         end
         default: begin
            state_in = tcq_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands and handshake outputs.
   always_comb begin
      cmd       = '0;
      busy      = (state_ff != tcq_pkg::ST_IDLE);
      rsp_valid = 1'b0;
      unique case (state_ff)
         tcq_pkg::ST_IDLE: begin
            cmd.latch = start;
         end
         tcq_pkg::ST_EXEC: begin
            unique case (status.req)
               tcq_pkg::REQ_ENQUEUE: cmd.do_enqueue = !status.full;
               tcq_pkg::REQ_TAKE:    cmd.scan_start = !status.empty;
               tcq_pkg::REQ_DROP:    cmd.do_drop    = !status.empty;
               default: begin
               end
            endcase
         end
         tcq_pkg::ST_SCAN: begin
            cmd.scan_step   = 1'b1;
            cmd.shift_start = status.step_done && status.found;
         end
         tcq_pkg::ST_SHIFT: begin
            cmd.shift_step  = 1'b1;
            cmd.take_commit = status.step_done;
         end
         tcq_pkg::ST_HEAD_RD: begin
            cmd.head_read = 1'b1;
         end
         tcq_pkg::ST_RESPOND: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== bench/timed_command_queue_tb.sv =====
`timescale 1ns / 100ps

module timed_command_queue_tb;

   localparam logic [tcq_pkg::REQ_W-1:0]  REQ_UNUSED  = 2'd3;
   localparam logic [tcq_pkg::TIME_W-1:0] TIME_MAX    = {tcq_pkg::TIME_W{1'b1}};
   localparam int                         CYCLE_LIMIT = 1_000_000;
   localparam int                         MAX_GAP     = 40;

   // One expected response from the queue.
   typedef struct {
      logic                            done;
      logic [tcq_pkg::TAG_W-1:0]       taken_tag;
      logic [tcq_pkg::TIME_W-1:0]      taken_time;
      logic [tcq_pkg::TAG_W-1:0]       head_tag;
      logic [tcq_pkg::OUT_COUNT_W-1:0] count;
   } queue_result_type;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [tcq_pkg::REQ_W-1:0]       req_type;
   logic [tcq_pkg::TIME_W-1:0]      req_now_time;
   logic [tcq_pkg::DELAY_W-1:0]     req_delay_ticks;
   logic [tcq_pkg::TAG_W-1:0]       req_cmd_tag;
   logic                            rsp_valid;
   logic                            rsp_done_res;
   logic [tcq_pkg::TAG_W-1:0]       rsp_taken_tag;
   logic [tcq_pkg::TIME_W-1:0]      rsp_taken_ready_time;
   logic [tcq_pkg::TAG_W-1:0]       rsp_head_tag;
   logic [tcq_pkg::OUT_COUNT_W-1:0] rsp_entry_count;

   // Shadow copy of the ring queue.
   logic [tcq_pkg::TAG_W-1:0]  shadow_tags  [tcq_pkg::QUEUE_DEPTH];
   logic [tcq_pkg::TIME_W-1:0] shadow_times [tcq_pkg::QUEUE_DEPTH];
   int unsigned                shadow_head;
   int unsigned                shadow_tail;
   int unsigned                shadow_count;

   queue_result_type pending_results [$];
   queue_result_type oldest_result;

   int          err_count;
   int          items_sent;
   int          results_seen;
   int          takes_found;
   int          enqueues_refused;
   int          saturations;
   int          cycle_count;
   int          idle_pct;
   logic [tcq_pkg::TIME_W-1:0] sim_now;

   timed_command_queue dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_type             (req_type),
      .req_now_time         (req_now_time),
      .req_delay_ticks      (req_delay_ticks),
      .req_cmd_tag          (req_cmd_tag),
      .rsp_valid            (rsp_valid),
      .rsp_done_res         (rsp_done_res),
      .rsp_taken_tag        (rsp_taken_tag),
      .rsp_taken_ready_time (rsp_taken_ready_time),
      .rsp_head_tag         (rsp_head_tag),
      .rsp_entry_count      (rsp_entry_count)
   );

   // Free-running clock, 4 ns period.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed_command_queue_tb: errors");
         $finish;
      end
   end

   // Apply one request to the shadow queue and return the response it should give.
   function automatic queue_result_type predict_queue_step(
         logic [tcq_pkg::REQ_W-1:0] kind,
         logic [tcq_pkg::TIME_W-1:0] now,
         logic [tcq_pkg::DELAY_W-1:0] delay,
         logic [tcq_pkg::TAG_W-1:0] tag);
      queue_result_type           res;
      logic [tcq_pkg::TIME_W:0]   sum;
      int unsigned                best;
      int unsigned                slot;
      bit                         found;

      res = '{done: 1'b0, taken_tag: '0, taken_time: '0, head_tag: '0, count: '0};
      best = 0;
      found = 1'b0;
      case (kind)
         tcq_pkg::REQ_ENQUEUE: begin
            sum = {1'b0, now} +
                  {{(tcq_pkg::TIME_W + 1 - tcq_pkg::DELAY_W){1'b0}}, delay};
            if (shadow_count >= tcq_pkg::QUEUE_DEPTH) begin
               enqueues_refused++;
            end else begin
               if (sum[tcq_pkg::TIME_W]) begin
                  saturations++;
               end
               shadow_tags[shadow_tail]  = tag;
               shadow_times[shadow_tail] = sum[tcq_pkg::TIME_W] ?
                                           TIME_MAX : sum[tcq_pkg::TIME_W-1:0];
               shadow_tail  = (shadow_tail + 1) % tcq_pkg::QUEUE_DEPTH;
               shadow_count = shadow_count + 1;
               res.done = 1'b1;
            end
         end
         tcq_pkg::REQ_TAKE: begin
            // Earliest ready time wins; a strict compare keeps the entry nearer the head.
            for (int k = 0; k < shadow_count; k++) begin
               slot = (shadow_head + k) % tcq_pkg::QUEUE_DEPTH;
               if (shadow_times[slot] <= now) begin
                  if (!found || shadow_times[slot] <
                      shadow_times[(shadow_head + best) % tcq_pkg::QUEUE_DEPTH]) begin
                     best  = k;
                     found = 1'b1;
                  end
               end
            end
            if (found) begin
               slot = (shadow_head + best) % tcq_pkg::QUEUE_DEPTH;
               res.done       = 1'b1;
               res.taken_tag  = shadow_tags[slot];
               res.taken_time = shadow_times[slot];
               // Close the gap by moving later entries down one place.
               for (int k = best; k + 1 < shadow_count; k++) begin
                  shadow_tags[(shadow_head + k) % tcq_pkg::QUEUE_DEPTH] =
                     shadow_tags[(shadow_head + k + 1) % tcq_pkg::QUEUE_DEPTH];
                  shadow_times[(shadow_head + k) % tcq_pkg::QUEUE_DEPTH] =
                     shadow_times[(shadow_head + k + 1) % tcq_pkg::QUEUE_DEPTH];
               end
               shadow_tail  = (shadow_tail + tcq_pkg::QUEUE_DEPTH - 1) % tcq_pkg::QUEUE_DEPTH;
               shadow_count = shadow_count - 1;
               takes_found++;
            end
         end
         tcq_pkg::REQ_DROP: begin
            if (shadow_count != 0) begin
               shadow_head  = (shadow_head + 1) % tcq_pkg::QUEUE_DEPTH;
               shadow_count = shadow_count - 1;
               res.done = 1'b1;
            end
         end
         default: begin
         end
      endcase
      res.head_tag = (shadow_count != 0) ? shadow_tags[shadow_head] : '0;
      res.count    = tcq_pkg::OUT_COUNT_W'(shadow_count);
      return res;
   endfunction

   // Present one item, hold it until the queue takes it, and log its expected response.
   task automatic send_item(logic [tcq_pkg::REQ_W-1:0] kind,
                            logic [tcq_pkg::TIME_W-1:0] now,
                            logic [tcq_pkg::DELAY_W-1:0] delay,
                            logic [tcq_pkg::TAG_W-1:0] tag);
      int gap;

      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_type        <= kind;
      req_now_time    <= now;
      req_delay_ticks <= delay;
      req_cmd_tag     <= tag;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      pending_results.push_back(predict_queue_step(kind, now, delay, tag));
      items_sent++;
   endtask

   // Compare every response with the oldest outstanding expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            err_count++;
            $error("response with no item outstanding");
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_done_res !== oldest_result.done) begin
               err_count++;
               $error("done_res: expected %0d, got %0d", oldest_result.done, rsp_done_res);
            end
            if (rsp_taken_tag !== oldest_result.taken_tag) begin
               err_count++;
               $error("taken_tag: expected %h, got %h", oldest_result.taken_tag, rsp_taken_tag);
            end
            if (rsp_taken_ready_time !== oldest_result.taken_time) begin
               err_count++;
               $error("taken_ready_time: expected %h, got %h",
                      oldest_result.taken_time, rsp_taken_ready_time);
            end
            if (rsp_head_tag !== oldest_result.head_tag) begin
               err_count++;
               $error("head_tag: expected %h, got %h", oldest_result.head_tag, rsp_head_tag);
            end
            if (rsp_entry_count !== oldest_result.count) begin
               err_count++;
               $error("entry_count: expected %0d, got %0d", oldest_result.count, rsp_entry_count);
            end
         end
      end
   end

   function automatic logic [tcq_pkg::TIME_W-1:0] random_time();
      return tcq_pkg::TIME_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [tcq_pkg::TAG_W-1:0] random_tag();
      return tcq_pkg::TAG_W'($urandom());
   endfunction

   // Field extremes, empty-queue requests, saturation, ties and the unused code.
   task automatic test_edge_cases();
      send_item(tcq_pkg::REQ_DROP, '0, '0, '0);
      send_item(tcq_pkg::REQ_TAKE, TIME_MAX, '1, '1);
      send_item(REQ_UNUSED, TIME_MAX, '1, '1);
      send_item(tcq_pkg::REQ_ENQUEUE, '0, '0, 16'hFFFF);
      send_item(tcq_pkg::REQ_ENQUEUE, TIME_MAX, '1, 16'h0001);
      send_item(tcq_pkg::REQ_ENQUEUE, 48'h7FFF_FFFF_FFFF, '1, 16'h8000);
      send_item(tcq_pkg::REQ_ENQUEUE, 48'd100, 32'd5, 16'h0000);
      send_item(tcq_pkg::REQ_ENQUEUE, 48'd95, 32'd10, 16'h1234);
      send_item(tcq_pkg::REQ_TAKE, 48'd104, '0, '0);
      send_item(tcq_pkg::REQ_TAKE, 48'd104, '0, '0);
      // Two entries ready at the same time: the one nearer the head goes first.
      send_item(tcq_pkg::REQ_TAKE, 48'd105, '0, '0);
      send_item(tcq_pkg::REQ_TAKE, TIME_MAX - 48'd1, '0, '0);
      send_item(tcq_pkg::REQ_TAKE, TIME_MAX, '0, '0);
      send_item(REQ_UNUSED, 48'd7, 32'd7, 16'h5555);
      send_item(tcq_pkg::REQ_DROP, '0, '0, '0);
      send_item(tcq_pkg::REQ_TAKE, TIME_MAX, '0, '0);
      send_item(tcq_pkg::REQ_DROP, '0, '0, '0);
      send_item(tcq_pkg::REQ_ENQUEUE, 48'd5, 32'd0, 16'hAAAA);
      send_item(tcq_pkg::REQ_ENQUEUE, 48'd3, 32'd0, 16'h5555);
      send_item(tcq_pkg::REQ_TAKE, 48'd2, '0, '0);
      send_item(tcq_pkg::REQ_TAKE, 48'd4, '0, '0);
      send_item(tcq_pkg::REQ_DROP, '0, '0, '0);
   endtask

   // Fill the queue, push against the limit, then remove from a full queue and drain it.
   task automatic test_full_queue();
      sim_now = random_time() >> 1;
      for (int i = 0; i < tcq_pkg::QUEUE_DEPTH; i++) begin
         send_item(tcq_pkg::REQ_ENQUEUE, sim_now, $urandom_range(15, 0), random_tag());
      end
      send_item(tcq_pkg::REQ_ENQUEUE, sim_now, $urandom(), random_tag());
      send_item(tcq_pkg::REQ_ENQUEUE, sim_now, $urandom(), random_tag());
      send_item(tcq_pkg::REQ_TAKE, sim_now + 48'd20, '0, '0);
      send_item(tcq_pkg::REQ_ENQUEUE, sim_now, $urandom_range(15, 0), random_tag());
      send_item(tcq_pkg::REQ_DROP, '0, '0, '0);
      send_item(tcq_pkg::REQ_ENQUEUE, sim_now, $urandom_range(15, 0), random_tag());
      send_item(tcq_pkg::REQ_TAKE, sim_now + 48'd8, '0, '0);
      for (int i = 0; i < tcq_pkg::QUEUE_DEPTH; i++) begin
         send_item(tcq_pkg::REQ_DROP, '0, '0, '0);
      end
   endtask

   // Random traffic with a given request mix; times cluster around a drifting clock.
   task automatic test_random_mix(int num_items, int idle, int enq_pct, int take_pct,
                                  int drop_pct, logic [tcq_pkg::TIME_W-1:0] base_time);
      logic [tcq_pkg::REQ_W-1:0]   kind;
      logic [tcq_pkg::TIME_W-1:0]  now;
      logic [tcq_pkg::DELAY_W-1:0] delay;
      int                          pick;

      idle_pct = idle;
      sim_now  = base_time;
      for (int i = 0; i < num_items; i++) begin
         sim_now = sim_now + tcq_pkg::TIME_W'($urandom_range(3, 0));
         pick = $urandom_range(99);
         if (pick < enq_pct) begin
            kind = tcq_pkg::REQ_ENQUEUE;
         end else if (pick < enq_pct + take_pct) begin
            kind = tcq_pkg::REQ_TAKE;
         end else if (pick < enq_pct + take_pct + drop_pct) begin
            kind = tcq_pkg::REQ_DROP;
         end else begin
            kind = REQ_UNUSED;
         end
         pick = $urandom_range(99);
         if (pick < 82) begin
            now = sim_now;
         end else if (pick < 92) begin
            now = random_time();
         end else if (pick < 96) begin
            now = TIME_MAX;
         end else begin
            now = '0;
         end
         pick = $urandom_range(99);
         if (pick < 70) begin
            delay = $urandom_range(15, 0);
         end else if (pick < 90) begin
            delay = $urandom_range(2000, 0);
         end else begin
            delay = $urandom();
         end
         send_item(kind, now, delay, random_tag());
      end
   endtask

   initial begin
      err_count        = 0;
      items_sent       = 0;
      results_seen     = 0;
      takes_found      = 0;
      enqueues_refused = 0;
      saturations      = 0;
      cycle_count      = 0;
      idle_pct         = 0;
      shadow_head      = 0;
      shadow_tail      = 0;
      shadow_count     = 0;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_type        <= tcq_pkg::REQ_ENQUEUE;
      req_now_time    <= '0;
      req_delay_ticks <= '0;
      req_cmd_tag     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_edge_cases();
      idle_pct = 76;
      test_full_queue();
      test_random_mix(215, 0, 50, 35, 12, random_time() >> 1);
      test_random_mix(215, 76, 65, 25, 7, TIME_MAX - 48'd5000);
      test_random_mix(215, 0, 40, 45, 12, random_time());
      test_random_mix(215, 21, 50, 35, 12, '0);

      start <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("Sent %0d items: %0d commands taken, %0d enqueues refused on a full queue,",
               items_sent, takes_found, enqueues_refused);
      $display("%0d ready times saturated; %0d responses checked.", saturations, results_seen);
      if (err_count == 0) begin
         $display("timed_command_queue_tb: clean");
      end else begin
         $display("timed_command_queue_tb: errors");
      end
      $finish;
   end

endmodule
